[rtl/core/cpre_pkg.sv]
// shared constants, types and the zone-count bound function for the cpr position encoder
`timescale 1ns / 1ps
`default_nettype none

package cpre_pkg;

    localparam int ANGLE_BITS = 32;
    // angle times a 7-bit signed zone count
    localparam int PROD_W     = ANGLE_BITS + 7;
    localparam int CODE_W     = 17;
    localparam int SCALE_AIR  = 17;
    localparam int SCALE_SURF = 19;
    // |z| stays within 30 zones of the surface scale
    localparam int Z_W        = 25;
    localparam int W_W        = 24;
    localparam int N_W        = 6;
    localparam int NL_COUNT   = 58;
    localparam int GROUPS     = 8;
    localparam int GROUP_BITS = 8;

    localparam logic [N_W-1:0] NZ_EVEN = 6'd60;
    localparam logic [N_W-1:0] NZ_ODD  = 6'd59;
    localparam logic [N_W-1:0] NL_MAX  = 6'd59;
    localparam logic [W_W-1:0] W_MAX   = W_W'(30) << SCALE_SURF;

    localparam logic signed [PROD_W-1:0] RND_AIR  =
        PROD_W'(1) << (ANGLE_BITS - 1 - SCALE_AIR);
    localparam logic signed [PROD_W-1:0] RND_SURF =
        PROD_W'(1) << (ANGLE_BITS - 1 - SCALE_SURF);

    localparam int S_TDATA_W = ((2 * ANGLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * CODE_W + 7) / 8) * 8;

    // 360 degrees in units of 1e-8 degree
    localparam logic [63:0] DEG_UNITS = 64'd36000000000;

    // zone transition latitudes in units of 1e-8 degree
    localparam logic [63:0] NL_THRESHOLD [NL_COUNT] = '{
        64'd1047047130, 64'd1482817437, 64'd1818626357, 64'd2102939493,
        64'd2354504487, 64'd2582924707, 64'd2793898710, 64'd2991135686,
        64'd3177209708, 64'd3353993436, 64'd3522899598, 64'd3685025108,
        64'd3841241892, 64'd3992256684, 64'd4138651832, 64'd4280914012,
        64'd4419454951, 64'd4554626723, 64'd4686733252, 64'd4816039128,
        64'd4942776439, 64'd5067150166, 64'd5189342469, 64'd5309516153,
        64'd5427817472, 64'd5544378444, 64'd5659318756, 64'd5772747354,
        64'd5884763776, 64'd5995459277, 64'd6104917774, 64'd6213216659,
        64'd6320427479, 64'd6426616523, 64'd6531845310, 64'd6636171008,
        64'd6739646774, 64'd6842322022, 64'd6944242631, 64'd7045451075,
        64'd7145986473, 64'd7245884545, 64'd7345177442, 64'd7443893416,
        64'd7542056257, 64'd7639684391, 64'd7736789461, 64'd7833374083,
        64'd7929428225, 64'd8024923213, 64'd8119801349, 64'd8213956981,
        64'd8307199445, 64'd8399173563, 64'd8489166191, 64'd8575541621,
        64'd8653536998, 64'd8700000000
    };

    typedef struct packed {
        logic [ANGLE_BITS-1:0] lat;
        logic [ANGLE_BITS-1:0] lon;
        logic                  odd;
        logic                  surf;
    } pos_t;

    typedef struct packed {
        logic [W_W-1:0]        w;
        logic [CODE_W-1:0]     lat_code;
        logic [ANGLE_BITS-1:0] lon;
        logic                  odd;
        logic                  surf;
    } lat_res_t;

    typedef struct packed {
        logic [N_W-1:0]        n;
        logic [CODE_W-1:0]     lat_code;
        logic [ANGLE_BITS-1:0] lon;
        logic                  surf;
    } nl_res_t;

    // smallest |z| on the 2^19 scale that lies at or beyond a transition;
    // the 87 degree edge counts only when strictly beyond
    function automatic logic [W_W-1:0] nl_bound(input int idx, input logic odd);
        logic [63:0] nz;
        logic [63:0] num;
        logic [63:0] b;
        nz  = odd ? 64'(NZ_ODD) : 64'(NZ_EVEN);
        num = (NL_THRESHOLD[idx] * nz) << SCALE_SURF;
        if (idx == NL_COUNT - 1) begin
            b = num / DEG_UNITS + 64'd1;
        end else begin
            b = (num + DEG_UNITS - 64'd1) / DEG_UNITS;
        end
        return b[W_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/cpr_position_encoder_top.sv]
// top level of the cpr position encoder: stream ports around the seven-stage pipeline
`timescale 1ns / 1ps
`default_nettype none

// cpr position encoder: turns a latitude/longitude pair (fractions of a full circle)
// into 17-bit compact position reporting latitude and longitude codes, even or odd
// frame and airborne or surface scale chosen per beat by s_tuser. the pipeline has
// seven register stages and takes one beat per cycle while m_tready stays high; each
// stage holds its own valid bit and fills any bubble while the output stalls, so
// s_tready only drops once every stage holds a beat. stage depth is set by the two
// angle-by-zone-count multipliers and the 58 parallel zone threshold compares. no
// state is kept between beats and there is no start-up pass after reset.

module cpr_position_encoder_top
    import cpre_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // lat_angle [ANGLE_BITS-1:0], lon_angle above it, zero padded to bytes
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // odd_format [0], surface_format [1]
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // lat_code [16:0], lon_code [33:17], zero padded to bytes
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    pos_t              pos;
    logic              lat_valid, lat_ready;
    lat_res_t          lat_data;
    logic              nl_valid, nl_ready;
    nl_res_t           nl_data;
    logic [CODE_W-1:0] lat_code, lon_code;

    assign pos.lat  = s_tdata[ANGLE_BITS-1:0];
    assign pos.lon  = s_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
    assign pos.odd  = s_tuser[0];
    assign pos.surf = s_tuser[1];

    cpre_lat_zone u_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pos),
        .out_valid (lat_valid),
        .out_ready (lat_ready),
        .out_data  (lat_data)
    );

    cpre_nl_lookup u_nl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lat_valid),
        .in_ready  (lat_ready),
        .in_data   (lat_data),
        .out_valid (nl_valid),
        .out_ready (nl_ready),
        .out_data  (nl_data)
    );

    cpre_lon_zone u_lon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (nl_valid),
        .in_ready  (nl_ready),
        .in_data   (nl_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .lat_code  (lat_code),
        .lon_code  (lon_code)
    );

    assign m_tdata = {{(M_TDATA_W - 2*CODE_W){1'b0}}, lon_code, lat_code};

    // back-pressure reaches the input only when the whole pipe is full and stalled
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline still had room");

    a_zone_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nl_valid |-> (nl_data.n >= N_W'(1) && nl_data.n <= NL_MAX))
        else $error("longitude zone count out of range");

    a_lat_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lat_valid |-> (lat_data.w <= W_MAX))
        else $error("latitude magnitude beyond thirty zones");

    a_air_mag_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (lat_valid && !lat_data.surf) |-> (lat_data.w[1:0] == 2'b00))
        else $error("airborne magnitude not rescaled to the surface grid");

endmodule

`default_nettype wire

[rtl/core/cpre_lat_zone.sv]
// latitude zone stages: angle times zone count, rounding to the code scale, magnitude
`timescale 1ns / 1ps
`default_nettype none

module cpre_lat_zone
    import cpre_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire pos_t     in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output lat_res_t      out_data
);

    logic                         v1_reg, v2_reg;
    logic                         en1, en2;
    logic signed [PROD_W-1:0]     p_reg, p_next;
    logic [ANGLE_BITS-1:0]        lon1_reg;
    logic                         odd1_reg, surf1_reg;
    logic [N_W-1:0]               nz;
    logic signed [PROD_W-1:0]     sh_air, sh_surf;
    logic signed [Z_W-1:0]        z;
    logic [Z_W-1:0]               zmag;
    lat_res_t                     res_reg, res_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        nz     = in_data.odd ? NZ_ODD : NZ_EVEN;
        p_next = $signed(in_data.lat) * $signed({1'b0, nz});
    end

    // round half up to the zone code scale, floor by arithmetic shift
    always_comb begin
        sh_air  = (p_reg + RND_AIR) >>> (ANGLE_BITS - SCALE_AIR);
        sh_surf = (p_reg + RND_SURF) >>> (ANGLE_BITS - SCALE_SURF);
        z       = surf1_reg ? sh_surf[Z_W-1:0] : sh_air[Z_W-1:0];
        zmag    = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
        res_next.w        = surf1_reg ? zmag[W_W-1:0] : (zmag[W_W-1:0] << 2);
        res_next.lat_code = z[CODE_W-1:0];
        res_next.lon      = lon1_reg;
        res_next.odd      = odd1_reg;
        res_next.surf     = surf1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            p_reg     <= p_next;
            lon1_reg  <= in_data.lon;
            odd1_reg  <= in_data.odd;
            surf1_reg <= in_data.surf;
        end
        if (en2 && v1_reg) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

[rtl/core/cpre_nl_lookup.sv]
// longitude zone count stages: threshold compares, grouped count, zone count per frame
`timescale 1ns / 1ps
`default_nettype none

module cpre_nl_lookup
    import cpre_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire lat_res_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output nl_res_t       out_data
);

    localparam int CNT_W = $clog2(GROUP_BITS + 1);
    localparam int TOT_W = $clog2(NL_COUNT + 1);
    localparam int PAD_W = GROUPS * GROUP_BITS - NL_COUNT;

    logic                        v3_reg, v4_reg, v5_reg;
    logic                        en3, en4, en5;
    logic [NL_COUNT-1:0]         ge;
    logic [NL_COUNT-1:0]         therm_reg;
    logic [GROUPS*GROUP_BITS-1:0] therm_pad;
    logic [CNT_W-1:0]            cnt_next [GROUPS];
    logic [CNT_W-1:0]            cnt_reg  [GROUPS];
    logic [TOT_W-1:0]            total;
    logic [TOT_W-1:0]            nl, n_wide;
    logic [CODE_W-1:0]           code3_reg, code4_reg;
    logic [ANGLE_BITS-1:0]       lon3_reg, lon4_reg;
    logic                        odd3_reg, odd4_reg, surf3_reg, surf4_reg;
    nl_res_t                     res_reg, res_next;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // thresholds rise with latitude, so the compares form a thermometer code
    for (genvar i = 0; i < NL_COUNT; i++) begin : g_cmp
        localparam logic [W_W-1:0] BOUND_EVEN = nl_bound(i, 1'b0);
        localparam logic [W_W-1:0] BOUND_ODD  = nl_bound(i, 1'b1);
        assign ge[i] = in_data.w >= (in_data.odd ? BOUND_ODD : BOUND_EVEN);
    end

    always_comb begin
        therm_pad = {{PAD_W{1'b0}}, therm_reg};
        for (int g = 0; g < GROUPS; g++) begin
            cnt_next[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++) begin
                cnt_next[g] = cnt_next[g] + CNT_W'(therm_pad[g*GROUP_BITS+b]);
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + TOT_W'(cnt_reg[g]);
        end
        nl     = TOT_W'(NL_MAX) - total;
        n_wide = nl - TOT_W'(odd4_reg);
        // odd frames at the pole zone still need one longitude zone
        if (n_wide == '0) begin
            n_wide = TOT_W'(1);
        end
        res_next.n        = n_wide[N_W-1:0];
        res_next.lat_code = code4_reg;
        res_next.lon      = lon4_reg;
        res_next.surf     = surf4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en3) begin
                v3_reg <= in_valid;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && in_valid) begin
            therm_reg <= ge;
            code3_reg <= in_data.lat_code;
            lon3_reg  <= in_data.lon;
            odd3_reg  <= in_data.odd;
            surf3_reg <= in_data.surf;
        end
        if (en4 && v3_reg) begin
            cnt_reg   <= cnt_next;
            code4_reg <= code3_reg;
            lon4_reg  <= lon3_reg;
            odd4_reg  <= odd3_reg;
            surf4_reg <= surf3_reg;
        end
        if (en5 && v4_reg) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

[rtl/core/cpre_lon_zone.sv]
// longitude zone stages: angle times zone count, fraction rounding, output register
`timescale 1ns / 1ps
`default_nettype none

module cpre_lon_zone
    import cpre_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire nl_res_t      in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [CODE_W-1:0] lat_code,
    output logic [CODE_W-1:0] lon_code
);

    localparam logic [ANGLE_BITS:0] RND_AIR_U  =
        (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1 - SCALE_AIR);
    localparam logic [ANGLE_BITS:0] RND_SURF_U =
        (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1 - SCALE_SURF);

    logic                      v6_reg, v7_reg;
    logic                      en6, en7;
    logic signed [PROD_W-1:0]  prod;
    logic [ANGLE_BITS-1:0]     r_reg;
    logic [CODE_W-1:0]         code6_reg;
    logic                      surf6_reg;
    logic [ANGLE_BITS:0]       sh_air, sh_surf;
    logic [CODE_W-1:0]         lon_next;
    logic [CODE_W-1:0]         lat_out_reg, lon_out_reg;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign in_ready = en6;

    // only the fraction of a zone survives: low angle bits of the product
    assign prod = $signed(in_data.lon) * $signed({1'b0, in_data.n});

    always_comb begin
        sh_air   = ({1'b0, r_reg} + RND_AIR_U) >> (ANGLE_BITS - SCALE_AIR);
        sh_surf  = ({1'b0, r_reg} + RND_SURF_U) >> (ANGLE_BITS - SCALE_SURF);
        lon_next = surf6_reg ? sh_surf[CODE_W-1:0] : sh_air[CODE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en6) begin
                v6_reg <= in_valid;
            end
            if (en7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en6 && in_valid) begin
            r_reg     <= prod[ANGLE_BITS-1:0];
            code6_reg <= in_data.lat_code;
            surf6_reg <= in_data.surf;
        end
        if (en7 && v6_reg) begin
            lat_out_reg <= code6_reg;
            lon_out_reg <= lon_next;
        end
    end

    assign out_valid = v7_reg;
    assign lat_code  = lat_out_reg;
    assign lon_code  = lon_out_reg;

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the cpr position encoder with its code predictor and scoreboard
`timescale 1ns / 1ps

package cpr_code_check_pkg;
    import cpre_pkg::*;

    // zone transition latitudes, 1e-8 degree units
    localparam longint ZONE_EDGE [58] = '{
        64'd1047047130, 64'd1482817437, 64'd1818626357, 64'd2102939493,
        64'd2354504487, 64'd2582924707, 64'd2793898710, 64'd2991135686,
        64'd3177209708, 64'd3353993436, 64'd3522899598, 64'd3685025108,
        64'd3841241892, 64'd3992256684, 64'd4138651832, 64'd4280914012,
        64'd4419454951, 64'd4554626723, 64'd4686733252, 64'd4816039128,
        64'd4942776439, 64'd5067150166, 64'd5189342469, 64'd5309516153,
        64'd5427817472, 64'd5544378444, 64'd5659318756, 64'd5772747354,
        64'd5884763776, 64'd5995459277, 64'd6104917774, 64'd6213216659,
        64'd6320427479, 64'd6426616523, 64'd6531845310, 64'd6636171008,
        64'd6739646774, 64'd6842322022, 64'd6944242631, 64'd7045451075,
        64'd7145986473, 64'd7245884545, 64'd7345177442, 64'd7443893416,
        64'd7542056257, 64'd7639684391, 64'd7736789461, 64'd7833374083,
        64'd7929428225, 64'd8024923213, 64'd8119801349, 64'd8213956981,
        64'd8307199445, 64'd8399173563, 64'd8489166191, 64'd8575541621,
        64'd8653536998, 64'd8700000000
    };
    localparam longint CIRCLE_UNITS = 64'd36000000000;
    localparam int     TOP_EDGE     = 57;

    typedef struct packed {
        logic [CODE_W-1:0] lat_code;
        logic [CODE_W-1:0] lon_code;
    } cpr_codes_t;

    // rounded position inside a zone, unmasked; whole gets the zone index
    function automatic longint zone_round(input longint angle, input longint zones,
                                          input int shift, output longint whole);
        longint prod;
        longint rem;
        prod  = angle * zones;
        rem   = prod & ((64'sd1 <<< ANGLE_BITS) - 1);
        whole = (prod - rem) >>> ANGLE_BITS;
        return ((rem <<< shift) + (64'sd1 <<< (ANGLE_BITS - 1))) >>> ANGLE_BITS;
    endfunction

    function automatic cpr_codes_t encode_position(input logic [ANGLE_BITS-1:0] lat_raw,
                                                   input logic [ANGLE_BITS-1:0] lon_raw,
                                                   input logic odd, input logic surf);
        cpr_codes_t res;
        int         shift;
        longint     nz;
        longint     q;
        longint     yz;
        longint     xz;
        longint     z;
        longint     lhs;
        longint     rhs;
        longint     ignored;
        longint     nl;
        shift = surf ? SCALE_SURF : SCALE_AIR;
        nz    = odd ? 59 : 60;
        yz    = zone_round(longint'($signed(lat_raw)), nz, shift, q);
        // reconstructed latitude before the mask decides the longitude zone count
        z     = q * (64'sd1 <<< shift) + yz;
        if (z < 0) begin
            z = -z;
        end
        lhs = z * CIRCLE_UNITS;
        nl  = 59;
        for (int i = 0; i < 58; i++) begin
            rhs = ZONE_EDGE[i] * (64'sd1 <<< shift) * nz;
            // the 87 degree edge only counts when strictly beyond
            if ((i == TOP_EDGE) ? (lhs > rhs) : (lhs >= rhs)) begin
                nl--;
            end
        end
        nl = nl - (odd ? 1 : 0);
        if (nl < 1) begin
            nl = 1;
        end
        xz = zone_round(longint'($signed(lon_raw)), nl, shift, ignored);
        res.lat_code = yz[CODE_W-1:0];
        res.lon_code = xz[CODE_W-1:0];
        return res;
    endfunction

    class cpr_code_board;
        cpr_codes_t  pending_codes[$];
        int unsigned positions = 0;
        int unsigned odd_count = 0;
        int unsigned surf_count = 0;
        int unsigned compared = 0;
        int unsigned errors = 0;

        function void note_position(input logic [S_TDATA_W-1:0] tdata,
                                    input logic [1:0] tuser);
            pending_codes.push_back(encode_position(tdata[ANGLE_BITS-1:0],
                                                    tdata[2*ANGLE_BITS-1:ANGLE_BITS],
                                                    tuser[0], tuser[1]));
            positions++;
            odd_count  += tuser[0];
            surf_count += tuser[1];
        endfunction

        function void check_codes(input logic [M_TDATA_W-1:0] tdata);
            cpr_codes_t want;
            logic [CODE_W-1:0] got_lat;
            logic [CODE_W-1:0] got_lon;
            got_lat = tdata[CODE_W-1:0];
            got_lon = tdata[2*CODE_W-1:CODE_W];
            if (pending_codes.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected code beat: lat_code %0d lon_code %0d", got_lat, got_lon);
                end
                return;
            end
            want = pending_codes.pop_front();
            compared++;
            if (got_lat !== want.lat_code || got_lon !== want.lon_code) begin
                errors++;
                if (errors <= 10) begin
                    $display("code beat %0d: lat_code exp %0d got %0d, lon_code exp %0d got %0d",
                             compared, want.lat_code, got_lat, want.lon_code, got_lon);
                end
            end
        endfunction

        function int unsigned waiting();
            return pending_codes.size();
        endfunction
    endclass

endpackage

module tb;
    import cpre_pkg::*;
    import cpr_code_check_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    cpr_code_board board = new;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    int rx_hold = 0;
    int idle_cycles = 0;

    cpr_position_encoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // results are checked before the same edge's input is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) begin
                board.check_codes(m_tdata);
            end
            if (s_tvalid && s_tready === 1'b1) begin
                board.note_position(s_tdata, s_tuser);
            end
        end
    end

    always @(posedge aclk) begin : rx_pace
        int roll;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                m_tready <= 1'b1;
            end else if (roll < 95) begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(9, 49);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("[cpr_position_encoder_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!tx_gaps || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // holds the beat until it is taken; valid stays high for a back-to-back beat
    task automatic send_position(input logic [ANGLE_BITS-1:0] lat,
                                 input logic [ANGLE_BITS-1:0] lon,
                                 input logic odd, input logic surf, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lon, lat};
        s_tuser  <= {surf, odd};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
    endtask

    task automatic drain_codes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.waiting() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [ANGLE_BITS-1:0] lat;
        logic [ANGLE_BITS-1:0] lon;
        longint                near;
        int                    kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_position(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 0);
        send_position(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 0);
        send_position(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 0);
        send_position(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 0);
        send_position(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, pick_gap());
        send_position(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, pick_gap());
        // a hair below a zone edge rounds up to a full zone and wraps
        send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0);
        send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 0);
        send_position(32'hFFFF_FFC0, 32'hFFFF_FFF0, 1'b1, 1'b0, 0);
        // exactly 87 degrees on the even grid, then the odd neighbour
        send_position(32'd1037950362, 32'h1234_5678, 1'b0, 1'b0, pick_gap());
        send_position(-32'sd1037950362, 32'h8765_4321, 1'b0, 1'b1, 0);
        send_position(32'd1037950362, 32'hDEAD_BEEF, 1'b1, 1'b0, 0);
        send_position(32'd1037950900, 32'h0F0F_0F0F, 1'b0, 1'b0, 0);
        // beyond 90 degrees either way
        send_position(32'h4400_0000, 32'h3C00_0000, 1'b1, 1'b0, 0);
        send_position(-32'sh5000_0000, 32'hC000_0001, 1'b0, 1'b1, pick_gap());
        send_position(32'h6000_0000, 32'h4000_0000, 1'b1, 1'b1, 0);
        // two latitudes just below the first zone edge
        send_position(32'd124911000, 32'h2000_0000, 1'b0, 1'b0, 0);
        send_position(32'd124913000, 32'h2000_0000, 1'b0, 1'b0, 0);
        send_position(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1, 0);
        send_position(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 0);
        drain_codes();

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_gaps   = (ph % 4 == 0) || (ph % 4 == 1);
            rx_stalls = (ph % 4 == 0) || (ph % 4 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                kind = $urandom_range(0, 9);
                lat  = $urandom;
                if (kind >= 5 && kind <= 7) begin
                    // near a zone-count edge: edge * 2^32 / 360e8 degrees
                    near = (ZONE_EDGE[$urandom_range(0, 57)] << 26) / 562500000;
                    near = near + $urandom_range(0, 4000) - 2000;
                    lat  = $urandom_range(0, 1) ? -near[ANGLE_BITS-1:0] : near[ANGLE_BITS-1:0];
                end else if (kind == 8) begin
                    lat = -$urandom_range(0, 20000);
                end else if (kind == 9) begin
                    lat = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
                end
                kind = $urandom_range(0, 9);
                lon  = $urandom;
                if (kind == 0) begin
                    lon = -$urandom_range(0, 20000);
                end else if (kind == 1) begin
                    lon = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                send_position(lat, lon, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pick_gap());
            end
            // hold off the sender until the pipeline has emptied
            drain_codes();
        end

        repeat (20) @(posedge aclk);
        $display("%0d positions sent (%0d odd frames, %0d surface), %0d code beats compared",
                 board.positions, board.odd_count, board.surf_count, board.compared);
        $display("zone edges, 87 degree edge, full-zone wrap and beyond-90 latitudes included; "
                 , "%0d mismatches", board.errors);
        if (board.errors == 0 && board.waiting() == 0) begin
            $display("[cpr_position_encoder_top] OK");
        end else begin
            $display("[cpr_position_encoder_top] ERROR");
        end
        $finish;
    end

endmodule
